FILE: rtl/msc_pkg.sv
package msc_pkg;

    localparam int MAX_TERM_INDEX  = 30;
    localparam int INPUT_FRAC_BITS = 27;

    localparam int X_W     = 32;   // angle width
    localparam int N_W     = 5;    // last_term_index width
    localparam int K_W     = 6;    // term index, up to 2*MAX_TERM_INDEX+1
    localparam int OUT_W   = 40;   // Q15.24 result width
    localparam int MAG_W   = 62;   // term magnitude, unsigned Q22.40
    localparam int PROD_W  = 64;   // one 32x32 partial product
    localparam int FULL_W  = 95;   // full 62x32 product plus rounding
    localparam int ACC_W   = 61;   // signed Q.32 accumulator
    localparam int TERM_FRAC = 40;

    localparam logic [63:0] TWO32 = 64'h0000_0001_0000_0000;

    // 1/k in Q0.32, rounded to nearest, for k >= 2
    localparam logic [31:0] RECIP_ROM [64] = '{
        32'd0,                                  32'd0,
        32'((TWO32 + 64'd1)  / 64'd2),          32'((TWO32 + 64'd1)  / 64'd3),
        32'((TWO32 + 64'd2)  / 64'd4),          32'((TWO32 + 64'd2)  / 64'd5),
        32'((TWO32 + 64'd3)  / 64'd6),          32'((TWO32 + 64'd3)  / 64'd7),
        32'((TWO32 + 64'd4)  / 64'd8),          32'((TWO32 + 64'd4)  / 64'd9),
        32'((TWO32 + 64'd5)  / 64'd10),         32'((TWO32 + 64'd5)  / 64'd11),
        32'((TWO32 + 64'd6)  / 64'd12),         32'((TWO32 + 64'd6)  / 64'd13),
        32'((TWO32 + 64'd7)  / 64'd14),         32'((TWO32 + 64'd7)  / 64'd15),
        32'((TWO32 + 64'd8)  / 64'd16),         32'((TWO32 + 64'd8)  / 64'd17),
        32'((TWO32 + 64'd9)  / 64'd18),         32'((TWO32 + 64'd9)  / 64'd19),
        32'((TWO32 + 64'd10) / 64'd20),         32'((TWO32 + 64'd10) / 64'd21),
        32'((TWO32 + 64'd11) / 64'd22),         32'((TWO32 + 64'd11) / 64'd23),
        32'((TWO32 + 64'd12) / 64'd24),         32'((TWO32 + 64'd12) / 64'd25),
        32'((TWO32 + 64'd13) / 64'd26),         32'((TWO32 + 64'd13) / 64'd27),
        32'((TWO32 + 64'd14) / 64'd28),         32'((TWO32 + 64'd14) / 64'd29),
        32'((TWO32 + 64'd15) / 64'd30),         32'((TWO32 + 64'd15) / 64'd31),
        32'((TWO32 + 64'd16) / 64'd32),         32'((TWO32 + 64'd16) / 64'd33),
        32'((TWO32 + 64'd17) / 64'd34),         32'((TWO32 + 64'd17) / 64'd35),
        32'((TWO32 + 64'd18) / 64'd36),         32'((TWO32 + 64'd18) / 64'd37),
        32'((TWO32 + 64'd19) / 64'd38),         32'((TWO32 + 64'd19) / 64'd39),
        32'((TWO32 + 64'd20) / 64'd40),         32'((TWO32 + 64'd20) / 64'd41),
        32'((TWO32 + 64'd21) / 64'd42),         32'((TWO32 + 64'd21) / 64'd43),
        32'((TWO32 + 64'd22) / 64'd44),         32'((TWO32 + 64'd22) / 64'd45),
        32'((TWO32 + 64'd23) / 64'd46),         32'((TWO32 + 64'd23) / 64'd47),
        32'((TWO32 + 64'd24) / 64'd48),         32'((TWO32 + 64'd24) / 64'd49),
        32'((TWO32 + 64'd25) / 64'd50),         32'((TWO32 + 64'd25) / 64'd51),
        32'((TWO32 + 64'd26) / 64'd52),         32'((TWO32 + 64'd26) / 64'd53),
        32'((TWO32 + 64'd27) / 64'd54),         32'((TWO32 + 64'd27) / 64'd55),
        32'((TWO32 + 64'd28) / 64'd56),         32'((TWO32 + 64'd28) / 64'd57),
        32'((TWO32 + 64'd29) / 64'd58),         32'((TWO32 + 64'd29) / 64'd59),
        32'((TWO32 + 64'd30) / 64'd60),         32'((TWO32 + 64'd30) / 64'd61),
        32'd0,                                  32'd0
    };

    typedef struct packed {
        logic           load;       // capture angle, clear sums
        logic           mul_lo;     // low partial product
        logic           mul_hi;     // high partial product
        logic           mul_fix;    // combine, round, clip into magnitude
        logic           sel_recip;  // multiply by 1/k instead of x
        logic           acc;        // add current term to its series
        logic           finish;     // round and clip both sums, emit beat
        logic [K_W-1:0] k;
    } t_dp_cmd;

endpackage

FILE: rtl/msc_ctrl.sv
module msc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_wr_en,
    input  logic [msc_pkg::N_W-1:0]   i_cfg_wr_data,
    output msc_pkg::t_dp_cmd          o_cmd
);

    localparam int K_W = msc_pkg::K_W;
    localparam int N_W = msc_pkg::N_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MLO  = 3'd2;
    localparam logic [2:0] S_MHI  = 3'd3;
    localparam logic [2:0] S_MFIX = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]     r_state, n_state;
    logic [K_W-1:0] r_k, n_k;
    logic [K_W-1:0] r_kmax, n_kmax;
    logic           r_phase, n_phase;
    logic [N_W-1:0] r_last_term;
    logic [N_W-1:0] n_clamp;

    assign busy = (r_state != S_IDLE);

    assign n_clamp = (r_last_term > N_W'(msc_pkg::MAX_TERM_INDEX))
                   ? N_W'(msc_pkg::MAX_TERM_INDEX) : r_last_term;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_kmax  = r_kmax;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.k = r_k;
        o_cmd.sel_recip = r_phase;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_kmax  = K_W'({n_clamp, 1'b1});   // 2n+1
                    n_k     = '0;
                    n_phase = 1'b0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_k == r_kmax) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_phase = 1'b0;
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_MFIX;
            end
            S_MFIX: begin
                o_cmd.mul_fix = 1'b1;
                // after the x multiply, scale by 1/k unless k is 1
                if (!r_phase && (r_k > K_W'(1))) begin
                    n_phase = 1'b1;
                    n_state = S_MLO;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_kmax      <= '0;
            r_phase     <= 1'b0;
            r_last_term <= N_W'(5);
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_kmax  <= n_kmax;
            r_phase <= n_phase;
            if (i_cfg_wr_en) begin
                r_last_term <= i_cfg_wr_data;
            end
        end
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted angle did not raise busy");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_k <= r_kmax)
        else $error("term index ran past last term");

    a_recip_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase && r_state != S_IDLE) |-> r_k > K_W'(1))
        else $error("reciprocal step on term zero or one");

endmodule

FILE: rtl/msc_dp.sv
module msc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msc_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [msc_pkg::X_W-1:0]    i_x_value,
    output logic                              o_valid,
    output logic signed [msc_pkg::OUT_W-1:0]  o_sine_sum,
    output logic signed [msc_pkg::OUT_W-1:0]  o_cosine_sum,
    output logic                              o_saturated
);

    localparam int X_W    = msc_pkg::X_W;
    localparam int MAG_W  = msc_pkg::MAG_W;
    localparam int PROD_W = msc_pkg::PROD_W;
    localparam int FULL_W = msc_pkg::FULL_W;
    localparam int ACC_W  = msc_pkg::ACC_W;
    localparam int OUT_W  = msc_pkg::OUT_W;
    localparam int S_W    = ACC_W - 8;          // sum after dropping 8 fraction bits
    localparam int Q_W    = MAG_W + 1 - 8;      // term rounded to Q.32

    localparam logic [FULL_W-1:0] RND_X =
        FULL_W'(1) << (msc_pkg::INPUT_FRAC_BITS - 1);
    localparam logic [FULL_W-1:0] RND_R = FULL_W'(1) << 31;
    localparam logic signed [S_W-1:0] OUT_HI =
        {{(S_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [S_W-1:0] OUT_LO =
        {{(S_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    logic [X_W-1:0]           r_xmag;
    logic                     r_xneg;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_tneg;
    logic [PROD_W-1:0]        r_prod_lo;
    logic [MAG_W-1:0]         r_prod_hi;
    logic signed [ACC_W-1:0]  r_acc_s;
    logic signed [ACC_W-1:0]  r_acc_c;
    logic                     r_clip;
    logic                     r_valid;
    logic signed [OUT_W-1:0]  r_sine;
    logic signed [OUT_W-1:0]  r_cosine;
    logic                     r_sat;

    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [FULL_W-1:0]        full;
    logic [FULL_W-1:0]        shifted;
    logic                     over;
    logic [MAG_W:0]           mag_rnd;
    logic [Q_W-1:0]           q32;
    logic signed [ACC_W-1:0]  term;
    logic                     term_neg;
    logic [OUT_W:0]           fin_s;
    logic [OUT_W:0]           fin_c;

    // round half up, arithmetic shift by 8, clip to the output range; MSB is the clip flag
    function automatic logic [OUT_W:0] fin_round(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic signed [S_W-1:0]   s;
        logic [OUT_W:0]          res;
        v = acc + ACC_W'(128);
        s = v[ACC_W-1:8];
        if (s > OUT_HI) begin
            res = {1'b1, OUT_HI[OUT_W-1:0]};
        end else if (s < OUT_LO) begin
            res = {1'b1, OUT_LO[OUT_W-1:0]};
        end else begin
            res = {1'b0, s[OUT_W-1:0]};
        end
        return res;
    endfunction

    // one shared 32x32 multiplier, low half of the magnitude first
    assign mul_b = i_cmd.sel_recip ? msc_pkg::RECIP_ROM[i_cmd.k] : r_xmag;
    assign mul_a = i_cmd.mul_hi ? {2'b00, r_mag[MAG_W-1:32]} : r_mag[31:0];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign full = {1'b0, r_prod_hi, 32'd0} + {31'd0, r_prod_lo}
                + (i_cmd.sel_recip ? RND_R : RND_X);
    assign shifted = i_cmd.sel_recip ? (full >> 32) : (full >> msc_pkg::INPUT_FRAC_BITS);
    assign over = |shifted[FULL_W-1:MAG_W];

    assign mag_rnd  = {1'b0, r_mag} + (MAG_W + 1)'(128);
    assign q32      = mag_rnd[MAG_W:8];
    assign term_neg = r_tneg ^ i_cmd.k[1];
    assign term     = term_neg ? -$signed(ACC_W'(q32)) : $signed(ACC_W'(q32));

    assign fin_s = fin_round(r_acc_s);
    assign fin_c = fin_round(r_acc_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xneg  <= i_x_value[X_W-1];
            r_xmag  <= i_x_value[X_W-1] ? (~i_x_value + X_W'(1)) : i_x_value;
            r_mag   <= MAG_W'(1) << msc_pkg::TERM_FRAC;
            r_tneg  <= 1'b0;
            r_acc_s <= '0;
            r_acc_c <= '0;
            r_clip  <= 1'b0;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_p[MAG_W-1:0];
        end
        if (i_cmd.mul_fix) begin
            r_mag <= over ? {MAG_W{1'b1}} : shifted[MAG_W-1:0];
            if (over) begin
                r_clip <= 1'b1;
            end
            if (!i_cmd.sel_recip) begin
                r_tneg <= r_tneg ^ r_xneg;
            end
        end
        if (i_cmd.acc) begin
            if (i_cmd.k[0]) begin
                r_acc_s <= r_acc_s + term;
            end else begin
                r_acc_c <= r_acc_c + term;
            end
        end
        if (i_cmd.finish) begin
            r_sine   <= fin_s[OUT_W-1:0];
            r_cosine <= fin_c[OUT_W-1:0];
            r_sat    <= r_clip | fin_s[OUT_W] | fin_c[OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_valid      = r_valid;
    assign o_sine_sum   = r_sine;
    assign o_cosine_sum = r_cosine;
    assign o_saturated  = r_sat;

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.finish))
        else $error("result beat without a finish command");

    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_acc_s == '0 && r_acc_c == '0 && !r_clip))
        else $error("sums not cleared on a new angle");

endmodule

FILE: rtl/maclaurin_sine_cosine.sv
// Maclaurin sine and cosine of one angle.
// Input: pulse start with i_x_value (signed Q4.27, radians) while busy is
// low; the angle is taken at that edge. busy stays high until the result
// is computed.
// Output: o_sine_sum and o_cosine_sum (signed Q15.24) with o_saturated are
// valid for exactly one cycle, marked by o_valid. There is no back-pressure;
// the receiver must take the beat when it appears.
// Config: i_cfg_wr_en / i_cfg_wr_data write last_term_index n (terms 0..n
// of each series, values above 30 act as 30). Write it only while idle.
// Datapath: terms x^k/k! for k = 0..2n+1 are built by one shared 32x32
// multiplier; each 62x32 product is formed from two partial products
// and a round/clip step, two products per term for k >= 2. No new angle
// is taken while busy; start is accepted again in the o_valid cycle.
// Reset: synchronous active low; returns to idle, drops any angle in flight
// and sets n to 5.
module maclaurin_sine_cosine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [msc_pkg::X_W-1:0]    i_x_value,
    input  logic                              i_cfg_wr_en,
    input  logic [msc_pkg::N_W-1:0]           i_cfg_wr_data,
    output logic                              o_valid,
    output logic signed [msc_pkg::OUT_W-1:0]  o_sine_sum,
    output logic signed [msc_pkg::OUT_W-1:0]  o_cosine_sum,
    output logic                              o_saturated
);

    msc_pkg::t_dp_cmd cmd;

    msc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (cmd)
    );

    msc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x_value    (i_x_value),
        .o_valid      (o_valid),
        .o_sine_sum   (o_sine_sum),
        .o_cosine_sum (o_cosine_sum),
        .o_saturated  (o_saturated)
    );

endmodule

FILE: tb/maclaurin_sine_cosine_checker.sv
module maclaurin_sine_cosine_checker
    import msc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [X_W-1:0]       i_x_value,
    input  logic                 i_cfg_wr_en,
    input  logic [N_W-1:0]       i_cfg_wr_data,
    input  logic                 i_valid,
    input  logic [OUT_W-1:0]     i_sine_sum,
    input  logic [OUT_W-1:0]     i_cosine_sum,
    input  logic                 i_saturated,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [N_W-1:0]    TERMS_AT_RESET = 5;
    localparam int unsigned       RECIP_FRAC     = 32;
    localparam logic [63:0]       TERM_LIMIT     = (64'd1 << 62) - 64'd1;
    localparam logic signed [63:0] OUT_HI        = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [63:0] OUT_LO        = 64'shFFFF_FF80_0000_0000;

    typedef struct packed {
        logic [OUT_W-1:0] sine;
        logic [OUT_W-1:0] cosine;
        logic             saturated;
    } t_sums;

    t_sums          sums_expected [$];
    logic [N_W-1:0] term_limit_n = TERMS_AT_RESET;
    int             fail_total   = 0;

    // 1/k in Q0.32, rounded to nearest
    function automatic logic [31:0] reciprocal_q32(input int unsigned k);
        logic [63:0] q;
        q = ((64'd1 << 32) + 64'(k >> 1)) / 64'(k);
        return q[31:0];
    endfunction

    // {clip, magnitude}: (m * f) >> sh rounded half up, clipped to Q22.40
    function automatic logic [64:0] scale_magnitude(input logic [63:0] m,
                                                    input logic [31:0] f,
                                                    input int unsigned sh);
        logic [95:0] prod;
        prod = ({32'd0, m} * {64'd0, f} + (96'd1 << (sh - 1))) >> sh;
        if (prod > {32'd0, TERM_LIMIT})
            return {1'b1, TERM_LIMIT};
        return {1'b0, prod[63:0]};
    endfunction

    // {clip, sum}: Q.32 accumulator to Q15.24, half up, clipped to 40 bits
    function automatic logic [OUT_W:0] round_clip(input logic [63:0] acc);
        logic signed [63:0] v;
        v = $signed(acc + 64'd128) >>> 8;
        if (v > OUT_HI)
            return {1'b1, OUT_HI[OUT_W-1:0]};
        if (v < OUT_LO)
            return {1'b1, OUT_LO[OUT_W-1:0]};
        return {1'b0, v[OUT_W-1:0]};
    endfunction

    function automatic t_sums predict_sine_cosine(input logic [X_W-1:0] angle,
                                                  input logic [N_W-1:0] n_reg);
        logic          angle_neg;
        logic [31:0]   angle_mag;
        int unsigned   n_used;
        logic [63:0]   mag;
        logic [64:0]   scaled;
        logic [63:0]   q32;
        logic [63:0]   sine_acc;
        logic [63:0]   cosine_acc;
        logic          term_neg;
        logic          clip;
        logic [OUT_W:0] rounded;
        t_sums         r;
        angle_neg  = angle[X_W-1];
        angle_mag  = angle_neg ? -angle : angle;
        n_used     = (n_reg > MAX_TERM_INDEX) ? MAX_TERM_INDEX : n_reg;
        mag        = 64'd1 << TERM_FRAC;
        term_neg   = 1'b0;
        clip       = 1'b0;
        sine_acc   = '0;
        cosine_acc = '0;
        for (int unsigned k = 0; k <= 2 * n_used + 1; k++) begin
            if (k > 0) begin
                scaled = scale_magnitude(mag, angle_mag, INPUT_FRAC_BITS);
                clip  |= scaled[64];
                mag    = scaled[63:0];
                if (k > 1) begin
                    scaled = scale_magnitude(mag, reciprocal_q32(k), RECIP_FRAC);
                    clip  |= scaled[64];
                    mag    = scaled[63:0];
                end
                term_neg ^= angle_neg;
            end
            q32 = (mag + 64'd128) >> 8;
            // series sign flips every second term
            if (term_neg ^ k[1])
                q32 = -q32;
            if (k[0])
                sine_acc += q32;
            else
                cosine_acc += q32;
        end
        rounded  = round_clip(sine_acc);
        clip    |= rounded[OUT_W];
        r.sine   = rounded[OUT_W-1:0];
        rounded  = round_clip(cosine_acc);
        clip    |= rounded[OUT_W];
        r.cosine = rounded[OUT_W-1:0];
        r.saturated = clip;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sums want;
        if (!i_rst_n) begin
            term_limit_n <= TERMS_AT_RESET;
            sums_expected.delete();
        end else begin
            // retire the older angle before taking a new one on the same edge
            if (i_valid) begin
                if (sums_expected.size() == 0) begin
                    $error("result beat with no angle outstanding: sine %0d cosine %0d",
                           $signed(i_sine_sum), $signed(i_cosine_sum));
                    fail_total++;
                end else begin
                    want = sums_expected.pop_front();
                    if (i_sine_sum !== want.sine) begin
                        $error("sine_sum: expected %0d, got %0d",
                               $signed(want.sine), $signed(i_sine_sum));
                        fail_total++;
                    end
                    if (i_cosine_sum !== want.cosine) begin
                        $error("cosine_sum: expected %0d, got %0d",
                               $signed(want.cosine), $signed(i_cosine_sum));
                        fail_total++;
                    end
                    if (i_saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, i_saturated);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy)
                sums_expected.push_back(predict_sine_cosine(i_x_value, term_limit_n));
            if (i_cfg_wr_en)
                term_limit_n <= i_cfg_wr_data;
        end
        o_pending    <= sums_expected.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/maclaurin_sine_cosine_tb.sv
module maclaurin_sine_cosine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          RANDOM_PHASES = 27;
    localparam int          PHASE_ITEMS   = 50;
    localparam int          DRAIN_CYCLES  = 450;

    localparam logic [X_W-1:0] ONE_RAD = 32'sd134217728;
    localparam logic [X_W-1:0] HALF_PI = 32'sd210828714;
    localparam logic [X_W-1:0] PI_RAD  = 32'sd421657428;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic signed [X_W-1:0]   i_x_value     = '0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [N_W-1:0]          i_cfg_wr_data = '0;
    logic                    busy;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_sine_sum;
    logic signed [OUT_W-1:0] o_cosine_sum;
    logic                    o_saturated;

    int          fail_count;
    int          pending_beats;
    int          idle_pct    = 8;
    int unsigned cycle_count = 0;

    logic [X_W-1:0] corner_angles [10] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, ONE_RAD, -ONE_RAD,
        HALF_PI, -HALF_PI, PI_RAD, 32'h7FFF_FFFF, 32'h8000_0000
    };

    maclaurin_sine_cosine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_value     (i_x_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .o_sine_sum    (o_sine_sum),
        .o_cosine_sum  (o_cosine_sum),
        .o_saturated   (o_saturated)
    );

    maclaurin_sine_cosine_checker sums_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_x_value     (i_x_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (o_valid),
        .i_sine_sum    (o_sine_sum),
        .i_cosine_sum  (o_cosine_sum),
        .i_saturated   (o_saturated),
        .o_fail_count  (fail_count),
        .o_pending     (pending_beats)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [X_W-1:0] random_angle();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0, 1, 2, 3: return r;
            4, 5, 6, 7: return {{2{r[29]}}, r[29:0]};    // within about 4 rad
            8:          return {{11{r[20]}}, r[20:0]};
            default:    return corner_angles[r[3:0] % 4'd10];
        endcase
    endfunction

    task automatic send_angle(input logic [X_W-1:0] angle);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_x_value <= angle;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
    endtask

    task automatic set_term_limit(input logic [N_W-1:0] n);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [N_W-1:0] n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners at the reset term count, then at n = 0, 31 and 1
        foreach (corner_angles[i])
            send_angle(corner_angles[i]);
        set_term_limit(0);
        send_angle(32'h0000_0000);
        send_angle(HALF_PI);
        send_angle(32'h8000_0000);
        send_angle(32'h7FFF_FFFF);
        set_term_limit(31);
        send_angle(PI_RAD);
        send_angle(-PI_RAD);
        send_angle(32'h8000_0000);
        send_angle(ONE_RAD);
        set_term_limit(1);
        send_angle(ONE_RAD);
        send_angle(-HALF_PI);
        send_angle(32'h7FFF_FFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_pct = (p < 9) ? 8 : (p < 18) ? 51 : 0;
            case (p)
                0:       n = 0;
                1:       n = 31;
                2:       n = 30;
                default: n = N_W'(($urandom_range(3) == 0) ? $urandom_range(3)
                                                           : $urandom_range(31));
            endcase
            set_term_limit(n);
            repeat (PHASE_ITEMS)
                send_angle(random_angle());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
